### rtl/b2da_pkg.sv
`default_nettype none

package b2da_pkg;

  // Input word width and decimal digit buffer size
  localparam int NUM_BITS   = 32;
  localparam int MAX_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = DIGIT_W * MAX_DIGITS;
  localparam int CHAR_W     = 6;

  // Counter widths
  localparam int CNT_W  = $clog2(NUM_BITS);
  localparam int NDIG_W = $clog2(MAX_DIGITS + 1);

  // ASCII code of '0', cut to the character width
  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_TRIM,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

### rtl/b2da_dabble.sv
`default_nettype none

// One double-dabble step: correct every BCD digit of five or more by adding
// three, then shift the whole BCD word left by one, taking in the next bit.
module b2da_dabble (
  input  wire logic [b2da_pkg::BCD_W-1:0] bcd_in,
  input  wire logic                       bit_in,
  output logic      [b2da_pkg::BCD_W-1:0] bcd_out
);
  import b2da_pkg::*;

  logic [BCD_W-1:0] corr;

  // Correct each digit on its own
  always_comb begin
    logic [DIGIT_W-1:0] d;
    d = '0;
    corr = bcd_in;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      d = bcd_in[i*DIGIT_W +: DIGIT_W];
      if (d >= DIGIT_W'(5)) begin
        corr[i*DIGIT_W +: DIGIT_W] = d + DIGIT_W'(3);
      end
    end
  end

  // Shift in the next binary bit; the top bit falls off (value modulo 10^digits)
  assign bcd_out = {corr[BCD_W-2:0], bit_in};

endmodule

`default_nettype wire

### rtl/binary_to_decimal_ascii.sv
`default_nettype none

// Binary to decimal ASCII converter. Each 32-bit unsigned input word is sent
// out as its decimal digits in ASCII, most significant first, without leading
// zeros (zero gives a single '0'); tlast marks the least significant digit.
// A word is accepted, converted in the shared shift-and-correct unit (one
// input bit a cycle), stripped of its leading zeros, and then sent digit by
// digit as the output takes them. in_tready is low from acceptance until the
// last digit has been loaded into the output register; that digit may still
// wait there while the next word is accepted.
module binary_to_decimal_ascii (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] number
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [5:0] digit_char, [7:6] zero
  output logic             out_tlast   // last_digit
);
  import b2da_pkg::*;

  state_t state_r, state_nxt;

  logic [NUM_BITS-1:0] num_r;
  logic [BCD_W-1:0]    bcd_r;
  logic [BCD_W-1:0]    dab_out;
  logic [CNT_W-1:0]    cnt_r;
  logic [NDIG_W-1:0]   ndig_r;
  logic [CHAR_W-1:0]   char_r;
  logic                last_r;
  logic                out_valid_r;

  logic [DIGIT_W-1:0]  top_digit;
  logic                load;
  logic                conv_step;
  logic                trim_skip;
  logic                emit_step;
  logic                out_free;

  assign top_digit = bcd_r[BCD_W-1 -: DIGIT_W];
  assign load      = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Shared conversion unit
  b2da_dabble u_dabble (
    .bcd_in  (bcd_r),
    .bit_in  (num_r[NUM_BITS-1]),
    .bcd_out (dab_out)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_CONV;
      ST_CONV: if (cnt_r == CNT_W'(NUM_BITS - 1)) state_nxt = ST_TRIM;
      ST_TRIM: if (!trim_skip) state_nxt = ST_EMIT;
      ST_EMIT: if (out_free && ndig_r == NDIG_W'(1)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready = 1'b0;
    conv_step = 1'b0;
    trim_skip = 1'b0;
    emit_step = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_CONV: conv_step = 1'b1;
      ST_TRIM: trim_skip = (top_digit == '0) && (ndig_r != NDIG_W'(1));
      ST_EMIT: emit_step = out_free;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_step) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath: take the word, convert, drop leading zeros, send digits
  always_ff @(posedge clk) begin
    if (load) begin
      num_r  <= in_tdata;
      bcd_r  <= '0;
      cnt_r  <= '0;
      ndig_r <= NDIG_W'(MAX_DIGITS);
    end
    if (conv_step) begin
      bcd_r <= dab_out;
      num_r <= {num_r[NUM_BITS-2:0], 1'b0};
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (trim_skip || emit_step) begin
      bcd_r  <= {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      ndig_r <= ndig_r - NDIG_W'(1);
    end
    if (emit_step) begin
      char_r <= ASCII_ZERO + CHAR_W'(top_digit);
      last_r <= (ndig_r == NDIG_W'(1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, char_r};
  assign out_tlast  = last_r;

  // A new word always starts conversion from the first bit
  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (state_r == ST_CONV) && (cnt_r == '0))
    else $error("conversion did not start after word accepted");

  // Sent characters are decimal digits
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (char_r >= CHAR_W'(48)) && (char_r <= CHAR_W'(57)))
    else $error("output character is not a decimal digit");

  // Digit count stays in range while trimming or sending
  a_ndig_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TRIM || state_r == ST_EMIT)
      |-> (ndig_r != '0) && (ndig_r <= NDIG_W'(MAX_DIGITS)))
    else $error("digit count out of range");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
module tb_top;
  import b2da_pkg::*;

  // One character word as it leaves the converter
  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } char_word_t;

  // Works out the decimal text of every accepted number and checks each
  // character word against the oldest one still outstanding
  class decimal_text_board;
    char_word_t pending_chars[$];
    int         failures;
    int         numbers_taken;
    int         chars_checked;

    function new();
      failures      = 0;
      numbers_taken = 0;
      chars_checked = 0;
    endfunction

    // Split into decimal digits, drop leading zeros, queue the characters
    function void accept_number(logic [31:0] number);
      logic [3:0]  dec [MAX_DIGITS];
      logic [31:0] rest;
      int          top;
      char_word_t  want;
      rest = number;
      top  = 0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        dec[i] = 4'(rest % 32'd10);
        rest   = rest / 32'd10;
        if (dec[i] != 4'd0) top = i;
      end
      for (int i = top; i >= 0; i--) begin
        want.digit_char = ASCII_ZERO + CHAR_W'(dec[i]);
        want.last_digit = (i == 0);
        pending_chars.push_back(want);
      end
      numbers_taken++;
    endfunction

    function void check_char(logic [CHAR_W-1:0] digit_char, logic last_digit);
      char_word_t want;
      chars_checked++;
      if (pending_chars.size() == 0) begin
        $error("unexpected digit word: digit_char %0d last_digit %0b",
               digit_char, last_digit);
        failures++;
        return;
      end
      want = pending_chars.pop_front();
      if (digit_char !== want.digit_char) begin
        $error("digit_char mismatch: expected %0d, actual %0d",
               want.digit_char, digit_char);
        failures++;
      end
      if (last_digit !== want.last_digit) begin
        $error("last_digit mismatch: expected %0b, actual %0b",
               want.last_digit, last_digit);
        failures++;
      end
    endfunction

    function int outstanding();
      return pending_chars.size();
    endfunction
  endclass

  localparam int RANDOM_NUMBERS = 390;
  localparam int HOLD_CYCLES    = 400;
  localparam int NUM_DIRECTED   = 24;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = 32'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;   // [5:0] digit_char, [7:6] zero
  logic        out_tlast;   // last_digit

  logic        calm       = 1'b0;
  logic        hold_done  = 1'b0;

  decimal_text_board board = new();

  binary_to_decimal_ascii u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Alternate stretches with and without idling
  initial begin
    forever begin
      repeat ($urandom_range(50, 300)) @(posedge clk);
      calm <= ~calm;
    end
  end

  // Mostly no pause, some short ones, now and then a long one
  function automatic int pick_pause(int long_max);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, long_max);
  endfunction

  function automatic longint unsigned pow10(int n);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  // Spread values over all digit counts, full-range words, round numbers
  // with runs of zeros, and values next to the powers of ten
  function automatic logic [31:0] pick_number();
    longint unsigned lo, hi, r, v;
    int              kind, n;
    kind = $urandom_range(0, 9);
    r    = {$urandom(), $urandom()};
    if (kind <= 5) begin
      n  = $urandom_range(1, 10);
      lo = (n == 1) ? 0 : pow10(n - 1);
      hi = pow10(n) - 1;
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      v  = lo + r % (hi - lo + 1);
    end else if (kind <= 7) begin
      v = $urandom();
    end else if (kind == 8) begin
      v = longint'($urandom_range(1, 9)) * pow10($urandom_range(0, 9))
          + longint'($urandom_range(0, 1));
      if (v > 64'hFFFF_FFFF) v = longint'($urandom_range(1, 4)) * pow10(9);
    end else begin
      v = pow10($urandom_range(1, 9)) + longint'($urandom_range(0, 2)) - 1;
    end
    return v[31:0];
  endfunction

  // Offer one word and hold it until the converter takes it
  task automatic send_number(logic [31:0] number);
    int pause;
    pause = pick_pause(60);
    if (pause > 0) begin
      in_tvalid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= number;
    do @(posedge clk); while (!in_tready);
    board.accept_number(number);
  endtask

  // Receive side: check every word taken, stall at random, and once hold
  // off long enough for the converter to back up onto its input
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready)
        board.check_char(out_tdata[CHAR_W-1:0], out_tlast);
      if (!hold_done && board.chars_checked >= 150) begin
        stall_left = HOLD_CYCLES;
        hold_done  = 1'b1;
      end else if (stall_left == 0) begin
        stall_left = pick_pause(40);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [31:0] directed [NUM_DIRECTED];
    directed = '{
      32'd0, 32'd1, 32'd7, 32'd9, 32'd10, 32'd19, 32'd90, 32'd99, 32'd100,
      32'd101, 32'd1000, 32'd12345, 32'd999999999, 32'd1000000000,
      32'd1000000001, 32'd500000000, 32'd2147483647, 32'd2147483648,
      32'd3999999999, 32'd4000000000, 32'd4294967290, 32'd4294967295,
      32'h5555_5555, 32'hAAAA_AAAA
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_number(directed[i]);
    for (int i = 0; i < RANDOM_NUMBERS; i++) send_number(pick_number());
    in_tvalid <= 1'b0;

    // Drain, then allow for anything still in flight
    while (board.outstanding() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("converted %0d numbers into %0d checked digit characters",
             board.numbers_taken, board.chars_checked);
    $display("included zero, all-ones, power-of-ten edges and a %0d-cycle output hold",
             HOLD_CYCLES);
    if (board.failures == 0 && board.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
rtl/b2da_pkg.sv
rtl/b2da_dabble.sv
rtl/binary_to_decimal_ascii.sv
tb/sv/tb_top.sv
